>>> hw/rtl/gidt_pkg.sv
`timescale 1ns / 1ps

package gidt_pkg;

    localparam int GROUP_ID_W = 16;
    localparam int REQ_TYPE_W = 2;
    localparam int ENTRY_W    = 5;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_LEAVE  = 2'd0,
        REQ_ENTER  = 2'd1,
        REQ_MEMBER = 2'd2
    } req_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESP
    } state_t;

endpackage

>>> hw/rtl/gidt_req_if.sv
`timescale 1ns / 1ps

interface gidt_req_if;
    logic                              valid;
    logic                              ready;
    logic [gidt_pkg::REQ_TYPE_W-1:0]   req_type;
    logic [gidt_pkg::GROUP_ID_W-1:0]   group_id;

    modport source (output valid, output req_type, output group_id, input ready);
    modport sink   (input valid, input req_type, input group_id, output ready);
endinterface

>>> hw/rtl/gidt_rsp_if.sv
`timescale 1ns / 1ps

interface gidt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic                           status;
    logic [gidt_pkg::ENTRY_W-1:0]   entry_count;

    modport source (output valid, output hit, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input hit, input status, input entry_count,
                    output ready);
endinterface

>>> hw/rtl/group_id_set_table_unit.sv
`timescale 1ns / 1ps

// Supplementary group id table with one request channel and one result channel.
// req carries req_type (leave, enter, member query) and group_id; it is taken
// only while the unit is idle, one request at a time.
// rsp returns hit, status and entry_count for every request, exactly once.
// cfg_wr_en with cfg_wr_data sets the primary group id; write only while idle.
// The table sits in one RAM with one read and one write port; a single
// comparator walks the valid slots, one slot a cycle, behind the registered read.
// An unused code goes straight to the result; any other request first walks
// the slots, stopping at the first match or after the last valid entry.
// A leave that hits then moves each later entry down one slot.
// The next request is taken in the cycle after the result is taken.
// Reset empties the table and clears the primary group to zero at once.
// While rsp.ready is low the result holds and req stays not ready.
module group_id_set_table_unit #(
    parameter int GROUP_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    gidt_req_if.sink                        req,
    gidt_rsp_if.source                      rsp,
    input  logic                            cfg_wr_en,
    input  logic [gidt_pkg::GROUP_ID_W-1:0] cfg_wr_data
);

    localparam int AW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;

    logic [gidt_pkg::GROUP_ID_W-1:0] primary_group_reg;
    logic [AW-1:0]                   rd_addr;
    logic [gidt_pkg::GROUP_ID_W-1:0] rd_data;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [gidt_pkg::GROUP_ID_W-1:0] wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_group_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            primary_group_reg <= cfg_wr_data;
        end
    end

    gidt_ctrl #(
        .GROUP_SLOTS (GROUP_SLOTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .primary_group (primary_group_reg),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    gidt_ram #(
        .WIDTH (gidt_pkg::GROUP_ID_W),
        .DEPTH (GROUP_SLOTS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

>>> hw/rtl/gidt_ram.sv
`timescale 1ns / 1ps

module gidt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/gidt_ctrl.sv
`timescale 1ns / 1ps

module gidt_ctrl #(
    parameter int GROUP_SLOTS = 16,
    localparam int CW = $clog2(GROUP_SLOTS + 1),
    localparam int AW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    gidt_req_if.sink                        req,
    gidt_rsp_if.source                      rsp,
    input  logic [gidt_pkg::GROUP_ID_W-1:0] primary_group,
    output logic [AW-1:0]                   rd_addr,
    input  logic [gidt_pkg::GROUP_ID_W-1:0] rd_data,
    output logic                            wr_en,
    output logic [AW-1:0]                   wr_addr,
    output logic [gidt_pkg::GROUP_ID_W-1:0] wr_data
);

    gidt_pkg::state_t                state_reg, state_next;
    logic [gidt_pkg::REQ_TYPE_W-1:0] op_reg, op_next;
    logic [gidt_pkg::GROUP_ID_W-1:0] id_reg, id_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [CW-1:0]                   pos_reg, pos_next;
    logic                            pend_reg, pend_next;
    logic                            hit_reg, hit_next;
    logic                            status_reg, status_next;

    logic match;
    logic issue;
    logic scan_end;
    logic shift_end;
    logic full;

    assign match     = pend_reg && (rd_data == id_reg);
    assign issue     = idx_reg < cnt_reg;
    assign scan_end  = match || (idx_reg == cnt_reg);
    assign shift_end = (idx_reg == cnt_reg) && !pend_reg;
    assign full      = cnt_reg == CW'(GROUP_SLOTS);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gidt_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == gidt_pkg::REQ_LEAVE ||
                        req.req_type == gidt_pkg::REQ_ENTER ||
                        req.req_type == gidt_pkg::REQ_MEMBER)
                    begin
                        state_next = gidt_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = gidt_pkg::ST_RESP;
                    end
                end
            end
            gidt_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (match && op_reg == gidt_pkg::REQ_LEAVE)
                    begin
                        state_next = gidt_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        state_next = gidt_pkg::ST_RESP;
                    end
                end
            end
            gidt_pkg::ST_SHIFT:
            begin
                if (shift_end)
                begin
                    state_next = gidt_pkg::ST_RESP;
                end
            end
            gidt_pkg::ST_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = gidt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gidt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        id_next     = id_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = pos_reg[AW-1:0];
        wr_data     = rd_data;

        unique case (state_reg)
            gidt_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.req_type;
                    id_next     = req.group_id;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    hit_next    = 1'b0;
                    status_next = 1'b0;
                end
            end
            gidt_pkg::ST_SCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (scan_end)
                begin
                    hit_next = match;
                    pos_next = idx_reg - CW'(1);
                    unique case (op_reg)
                        gidt_pkg::REQ_ENTER:
                        begin
                            if (!match)
                            begin
                                if (full)
                                begin
                                    status_next = 1'b1;
                                end
                                else
                                begin
                                    wr_en    = 1'b1;
                                    wr_addr  = cnt_reg[AW-1:0];
                                    wr_data  = id_reg;
                                    cnt_next = cnt_reg + CW'(1);
                                end
                            end
                        end
                        gidt_pkg::REQ_MEMBER:
                        begin
                            hit_next = match || (id_reg == primary_group);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            gidt_pkg::ST_SHIFT:
            begin
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    wr_en    = 1'b1;
                    pos_next = pos_reg + CW'(1);
                end
                if (shift_end)
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready       = state_reg == gidt_pkg::ST_IDLE;
    assign rsp.valid       = state_reg == gidt_pkg::ST_RESP;
    assign rsp.hit         = hit_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = gidt_pkg::ENTRY_W'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gidt_pkg::ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        pos_reg    <= pos_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
    end

endmodule
